### rtl/core/segment_disjoint_test_defines.svh
// Assertion macros for the segment disjoint test core.
// Included by the top level; the SYNTH build compiles them to nothing.
`ifndef SEGMENT_DISJOINT_TEST_DEFINES_SVH
`define SEGMENT_DISJOINT_TEST_DEFINES_SVH

`ifndef SYNTH
`define SDT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SDT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/sdt_pkg.sv
// Shared constants for the segment disjoint test pipeline.
// Holds the difference and product index tables and the term indexes; no dependencies.
package sdt_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int NUM_COORD       = 8;   // ax ay bx by cx cy dx dy
   localparam int RSP_TDATA_W     = 8;

   // Point indexes
   localparam int PT_A = 0;
   localparam int PT_B = 1;
   localparam int PT_C = 2;
   localparam int PT_D = 3;

   // Difference vectors P - Q: BA CA DA DC AC BC AD BD CB DB
   localparam int NUM_VEC  = 10;
   localparam int NUM_DIFF = 2 * NUM_VEC;  // index 2*vec + component
   localparam int VEC_P [NUM_VEC] = '{PT_B, PT_C, PT_D, PT_D, PT_A,
                                      PT_B, PT_A, PT_B, PT_C, PT_D};
   localparam int VEC_Q [NUM_VEC] = '{PT_A, PT_A, PT_A, PT_C, PT_C,
                                      PT_C, PT_D, PT_D, PT_B, PT_B};

   // Cross and dot products
   localparam int CROSS_AB_C = 0;
   localparam int CROSS_AB_D = 1;
   localparam int CROSS_CD_A = 2;
   localparam int CROSS_CD_B = 3;
   localparam int DOT_AB_C   = 4;
   localparam int DOT_AB_D   = 5;
   localparam int DOT_CD_A   = 6;
   localparam int DOT_CD_B   = 7;
   localparam int NUM_CROSS  = 4;
   localparam int NUM_SUM    = 8;
   localparam int NUM_PROD   = 2 * NUM_SUM;

   // Product 2k+j multiplies difference PROD_L by PROD_R; cross terms
   // subtract the second product, dot terms add it.
   localparam int PROD_L [NUM_PROD] = '{0, 1, 0, 1, 6, 7, 6, 7,
                                        8, 9, 12, 13, 2, 3, 16, 17};
   localparam int PROD_R [NUM_PROD] = '{3, 2, 5, 4, 9, 8, 11, 10,
                                        10, 11, 14, 15, 4, 5, 18, 19};

endpackage

### rtl/core/sdt_diff.sv
// Stage one: coordinate differences for all cross and dot product operands.
// Depends on sdt_pkg for the vector tables.
module sdt_diff #(
   parameter int COORD_WIDTH = sdt_pkg::COORD_WIDTH_DEF,
   localparam int DW = COORD_WIDTH + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] coord [sdt_pkg::NUM_COORD],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [DW-1:0]          diff [sdt_pkg::NUM_DIFF]
);

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [DW-1:0] diff_ff [sdt_pkg::NUM_DIFF];
   logic signed [DW-1:0] diff_in [sdt_pkg::NUM_DIFF];

   for (genvar i = 0; i < sdt_pkg::NUM_DIFF; i++) begin : g_diff
      localparam int PI = 2 * sdt_pkg::VEC_P[i / 2] + (i % 2);
      localparam int QI = 2 * sdt_pkg::VEC_Q[i / 2] + (i % 2);
      assign diff_in[i] = $signed({coord[PI][COORD_WIDTH-1], coord[PI]})
                        - $signed({coord[QI][COORD_WIDTH-1], coord[QI]});
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         diff_ff <= diff_in;
      end
   end

   assign out_valid = valid_ff;
   assign diff      = diff_ff;

endmodule

### rtl/core/sdt_mult.sv
// Stage two: the sixteen partial products of the cross and dot terms.
// Depends on sdt_pkg for the operand index tables.
module sdt_mult #(
   parameter int COORD_WIDTH = sdt_pkg::COORD_WIDTH_DEF,
   localparam int DW = COORD_WIDTH + 1,
   localparam int PW = 2 * DW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [DW-1:0] diff [sdt_pkg::NUM_DIFF],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [PW-1:0] prod [sdt_pkg::NUM_PROD]
);

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [PW-1:0] prod_ff [sdt_pkg::NUM_PROD];
   logic signed [PW-1:0] prod_in [sdt_pkg::NUM_PROD];

   for (genvar i = 0; i < sdt_pkg::NUM_PROD; i++) begin : g_prod
      assign prod_in[i] = PW'(diff[sdt_pkg::PROD_L[i]]) * PW'(diff[sdt_pkg::PROD_R[i]]);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

### rtl/core/sdt_sum.sv
// Stage three: combines product pairs into four cross and four dot products.
// Depends on sdt_pkg for the term counts.
module sdt_sum #(
   parameter int COORD_WIDTH = sdt_pkg::COORD_WIDTH_DEF,
   localparam int PW = 2 * (COORD_WIDTH + 1),
   localparam int SW = PW + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [PW-1:0] prod [sdt_pkg::NUM_PROD],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [SW-1:0] term [sdt_pkg::NUM_SUM]
);

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [SW-1:0] term_ff [sdt_pkg::NUM_SUM];
   logic signed [SW-1:0] term_in [sdt_pkg::NUM_SUM];

   for (genvar k = 0; k < sdt_pkg::NUM_SUM; k++) begin : g_term
      if (k < sdt_pkg::NUM_CROSS) begin : g_cross
         assign term_in[k] = SW'(prod[2*k]) - SW'(prod[2*k+1]);
      end else begin : g_dot
         assign term_in[k] = SW'(prod[2*k]) + SW'(prod[2*k+1]);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         term_ff <= term_in;
      end
   end

   assign out_valid = valid_ff;
   assign term      = term_ff;

endmodule

### rtl/core/sdt_decide.sv
// Stage four: sign tests and the collinear overlap check; holds the result.
// Depends on sdt_pkg for the cross and dot indexes.
module sdt_decide #(
   parameter int COORD_WIDTH = sdt_pkg::COORD_WIDTH_DEF,
   localparam int SW = 2 * (COORD_WIDTH + 1) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [SW-1:0] term [sdt_pkg::NUM_SUM],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 disjoint
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          disjoint_ff;
   logic                          disjoint_in;
   logic [sdt_pkg::NUM_CROSS-1:0] zero;
   logic [sdt_pkg::NUM_CROSS-1:0] neg;
   logic [sdt_pkg::NUM_CROSS-1:0] on_seg;
   logic                          same_tu;

   for (genvar k = 0; k < sdt_pkg::NUM_CROSS; k++) begin : g_sign
      assign zero[k] = (term[k] == '0);
      assign neg[k]  = term[k][SW-1];
      // endpoint on the other segment: on its line and dot product <= 0
      assign on_seg[k] = zero[k] && (term[k + sdt_pkg::NUM_CROSS][SW-1]
                         || term[k + sdt_pkg::NUM_CROSS] == '0);
   end

   assign same_tu = (zero[sdt_pkg::CROSS_AB_C] == zero[sdt_pkg::CROSS_AB_D])
                 && (neg[sdt_pkg::CROSS_AB_C] == neg[sdt_pkg::CROSS_AB_D]);

   always_comb begin
      if (same_tu && !zero[sdt_pkg::CROSS_AB_C]) begin
         disjoint_in = 1'b1;
      end else if (same_tu) begin
         disjoint_in = ~|on_seg;
      end else begin
         disjoint_in = (zero[sdt_pkg::CROSS_CD_A] == zero[sdt_pkg::CROSS_CD_B])
                    && (neg[sdt_pkg::CROSS_CD_A] == neg[sdt_pkg::CROSS_CD_B]);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         disjoint_ff <= disjoint_in;
      end
   end

   assign out_valid = valid_ff;
   assign disjoint  = disjoint_ff;

endmodule

### rtl/core/segment_disjoint_test.sv
// Segment disjoint test: four register stages (differences, products, sums, decision).
// A request's result is registered in turn by the diff, mult, sum and decide stages.
// One request per cycle unless all stages are full; longest path: a 17x17 multiply.
// Backpressure ripples stage by stage, so bubbles are filled while the output waits.
// Reset (synchronous, active high) clears all stage valid bits; payload is not reset.
// Depends on sdt_pkg, the sdt_* stage modules and segment_disjoint_test_defines.svh.
`include "segment_disjoint_test_defines.svh"

module segment_disjoint_test #(
   parameter int COORD_WIDTH = sdt_pkg::COORD_WIDTH_DEF,
   localparam int REQ_W = ((sdt_pkg::NUM_COORD * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y (low to high)
   input  logic [REQ_W-1:0]                req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // bit 0: disjoint; upper bits zero
   output logic [sdt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic signed [COORD_WIDTH-1:0] coord [sdt_pkg::NUM_COORD];
   logic signed [DW-1:0]          diff  [sdt_pkg::NUM_DIFF];
   logic signed [PW-1:0]          prod  [sdt_pkg::NUM_PROD];
   logic signed [SW-1:0]          term  [sdt_pkg::NUM_SUM];
   logic diff_valid, diff_ready;
   logic prod_valid, prod_ready;
   logic term_valid, term_ready;
   logic disjoint;

   for (genvar i = 0; i < sdt_pkg::NUM_COORD; i++) begin : g_coord
      assign coord[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
   end

   sdt_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coord     (coord),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .diff      (diff)
   );

   sdt_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .diff      (diff),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .prod      (prod)
   );

   sdt_sum #(.COORD_WIDTH(COORD_WIDTH)) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .prod      (prod),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .term      (term)
   );

   sdt_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .term      (term),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .disjoint  (disjoint)
   );

   assign rsp_tdata = {(sdt_pkg::RSP_TDATA_W - 1)'(0), disjoint};

   // input stalls only when every stage is full and the output is held
   `SDT_ASSERT_IMPL(a_stall_full, clock, reset, !req_tready, rsp_tvalid && !rsp_tready && term_valid && prod_valid && diff_valid, "request stalled with a free stage")
   `SDT_ASSERT_NEXT(a_accept_fill, clock, reset, req_tvalid && req_tready, diff_valid, "accepted request missing from first stage")
   `SDT_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(term_valid), "result without a request in the sum stage")
   `SDT_ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid && !diff_valid, "pipeline not empty after reset")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for segment_disjoint_test: directed and random segment pairs checked
// against an exact integer predictor, with bursty requests and a stalling receiver.
// Depends on sdt_pkg and the segment_disjoint_test RTL.
module tb;

   localparam int CW             = sdt_pkg::COORD_WIDTH_DEF;
   localparam int REQ_W          = ((sdt_pkg::NUM_COORD * CW + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct {
      longint x;
      longint y;
   } point_type;
   typedef enum int {RX_READY, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_type;

   localparam coord_type CMAX = coord_type'((1 << (CW - 1)) - 1);
   localparam coord_type CMIN = coord_type'(-(1 << (CW - 1)));

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sdt_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   bit          expected_disjoint [$];
   int          error_count   = 0;
   int          result_count  = 0;
   int          idle_cycles   = 0;
   int          burst_left    = 0;
   int          rx_phase_left = 0;
   int          rx_hold_left  = 0;
   rx_mode_type rx_mode       = RX_READY;
   bit          want;

   segment_disjoint_test #(.COORD_WIDTH(CW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // ---------------- predictor ----------------

   // cross(E-O, P-O)
   function automatic longint cross_about(point_type o, point_type e, point_type p);
      return (e.x - o.x) * (p.y - o.y) - (e.y - o.y) * (p.x - o.x);
   endfunction

   function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic bit lies_on(point_type s, point_type e, point_type p);
      if (cross_about(s, e, p) != 0)
         return 1'b0;
      return ((s.x - p.x) * (e.x - p.x) + (s.y - p.y) * (e.y - p.y)) <= 0;
   endfunction

   function automatic bit predict_disjoint(logic [REQ_W-1:0] data);
      point_type pt [4];
      int        t;
      int        u;
      for (int i = 0; i < 4; i++) begin
         pt[i].x = longint'(coord_type'(data[(2*i)*CW +: CW]));
         pt[i].y = longint'(coord_type'(data[(2*i+1)*CW +: CW]));
      end
      t = sign_of(cross_about(pt[sdt_pkg::PT_A], pt[sdt_pkg::PT_B], pt[sdt_pkg::PT_C]));
      u = sign_of(cross_about(pt[sdt_pkg::PT_A], pt[sdt_pkg::PT_B], pt[sdt_pkg::PT_D]));
      if (t == u) begin
         if (t != 0)
            return 1'b1;
         // all four points on one line
         return !(lies_on(pt[sdt_pkg::PT_A], pt[sdt_pkg::PT_B], pt[sdt_pkg::PT_C]) ||
                  lies_on(pt[sdt_pkg::PT_A], pt[sdt_pkg::PT_B], pt[sdt_pkg::PT_D]) ||
                  lies_on(pt[sdt_pkg::PT_C], pt[sdt_pkg::PT_D], pt[sdt_pkg::PT_A]) ||
                  lies_on(pt[sdt_pkg::PT_C], pt[sdt_pkg::PT_D], pt[sdt_pkg::PT_B]));
      end
      return sign_of(cross_about(pt[sdt_pkg::PT_C], pt[sdt_pkg::PT_D], pt[sdt_pkg::PT_A])) ==
             sign_of(cross_about(pt[sdt_pkg::PT_C], pt[sdt_pkg::PT_D], pt[sdt_pkg::PT_B]));
   endfunction

   // ---------------- request side ----------------

   function automatic coord_type rand_coord(int lo, int hi);
      return coord_type'(int'($urandom_range(0, hi - lo)) + lo);
   endfunction

   task automatic send_pair(input coord_type ax, ay, bx, by, cx, cy, dx, dy);
      logic [REQ_W-1:0] data;
      int               gap;
      data = {dy, dx, cy, cx, by, bx, ay, ax};
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         gap = $urandom_range(0, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_disjoint = {expected_disjoint, predict_disjoint(data)};
   endtask

   // hold off new requests until every pending result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_disjoint.size() != 0) @(posedge clock);
   endtask

   // ---------------- result side ----------------

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch on result %0d: %s", $time, result_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (rx_phase_left == 0) begin
         rx_mode       = rx_mode_type'($urandom_range(0, 3));
         rx_phase_left = $urandom_range(16, 160);
      end else begin
         rx_phase_left--;
      end
      case (rx_mode)
         RX_READY:  rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (rx_hold_left != 0) begin
               rx_hold_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 5) == 0)
                  rx_hold_left = $urandom_range(1, 24);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_disjoint.size() == 0) begin
            report_mismatch("result with no request pending");
         end else begin
            want = expected_disjoint.pop_front();
            if (rsp_tdata[0] !== want)
               report_mismatch($sformatf("disjoint got %b want %b", rsp_tdata[0], want));
            if (rsp_tdata[sdt_pkg::RSP_TDATA_W-1:1] !== '0)
               report_mismatch($sformatf("upper bits nonzero: %h", rsp_tdata));
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("** segment_disjoint_test: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      send_pair(0, 0, 10, 10, 0, 10, 10, 0);       // proper crossing
      send_pair(0, 0, 10, 0, 0, 5, 10, 5);         // parallel, apart
      send_pair(0, 0, 10, 0, 5, 0, 15, 0);         // collinear overlap
      send_pair(0, 0, 10, 0, 10, 0, 20, 0);        // collinear, shared endpoint
      send_pair(0, 0, 10, 0, 11, 0, 20, 0);        // collinear, gap of one
      send_pair(0, 0, 10, 0, 5, 0, 5, 9);          // T junction
      send_pair(0, 0, 10, 0, 5, 1, 5, 9);          // near miss above
      send_pair(0, 0, 10, 0, 20, -5, 20, 5);       // lines cross past the end
      send_pair(5, 5, 5, 5, 0, 0, 10, 10);         // point on segment
      send_pair(5, 6, 5, 6, 0, 0, 10, 10);         // point off segment
      send_pair(3, 3, 3, 3, 3, 3, 3, 3);           // two equal points
      send_pair(3, 3, 3, 3, 4, 3, 4, 3);           // two distinct points
      send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
      send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
      send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX);
      send_pair(CMIN, CMIN, -1, -1, 0, 0, CMAX, CMAX);
      send_pair(0, 0, 20, 0, 5, 0, 6, 0);          // collinear containment
      send_pair(0, 0, 4, 8, 0, 0, 0, 0);           // point at an endpoint
      send_pair(0, 0, 10, 0, 15, 0, 15, 5);        // one cross product zero
      send_pair(0, 10, 0, 0, 0, 3, 0, -3);         // vertical, reversed ends
      send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
      wait_for_results();
   endtask

   task automatic test_random_full(input int count);
      repeat (count)
         send_pair(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom));
   endtask

   // small grid: touching, collinear and degenerate pairs come up often
   task automatic test_random_small(input int count);
      repeat (count)
         send_pair(rand_coord(-6, 6), rand_coord(-6, 6), rand_coord(-6, 6),
                   rand_coord(-6, 6), rand_coord(-6, 6), rand_coord(-6, 6),
                   rand_coord(-6, 6), rand_coord(-6, 6));
   endtask

   task automatic test_random_collinear(input int count);
      int bx, by, vx, vy;
      int k [4];
      int nudge;
      repeat (count) begin
         bx = int'(rand_coord(-32000, 32000));
         by = int'(rand_coord(-32000, 32000));
         vx = int'(rand_coord(-4, 4));
         vy = int'(rand_coord(-4, 4));
         foreach (k[i]) k[i] = int'(rand_coord(-40, 40));
         // a few near-collinear pairs
         nudge = ($urandom_range(0, 7) == 0) ? int'(rand_coord(-1, 1)) : 0;
         send_pair(coord_type'(bx + k[0]*vx), coord_type'(by + k[0]*vy),
                   coord_type'(bx + k[1]*vx), coord_type'(by + k[1]*vy),
                   coord_type'(bx + k[2]*vx), coord_type'(by + k[2]*vy + nudge),
                   coord_type'(bx + k[3]*vx), coord_type'(by + k[3]*vy));
      end
   endtask

   // one endpoint placed on (or just past) the other segment
   task automatic test_random_touching(input int count);
      int sx, sy, vx, vy, m, j, ex, ey;
      repeat (count) begin
         sx = int'(rand_coord(-1000, 1000));
         sy = int'(rand_coord(-1000, 1000));
         vx = int'(rand_coord(-50, 50));
         vy = int'(rand_coord(-50, 50));
         m  = $urandom_range(0, 20);
         j  = $urandom_range(0, m + 1);
         ex = int'(rand_coord(-2000, 2000));
         ey = int'(rand_coord(-2000, 2000));
         if ($urandom_range(0, 1))
            send_pair(coord_type'(sx), coord_type'(sy),
                      coord_type'(sx + m*vx), coord_type'(sy + m*vy),
                      coord_type'(sx + j*vx), coord_type'(sy + j*vy),
                      coord_type'(ex), coord_type'(ey));
         else
            send_pair(coord_type'(ex), coord_type'(ey),
                      coord_type'(sx + j*vx), coord_type'(sy + j*vy),
                      coord_type'(sx + m*vx), coord_type'(sy + m*vy),
                      coord_type'(sx), coord_type'(sy));
      end
   endtask

   task automatic test_pause_until_drained();
      repeat (3) begin
         test_random_full(20);
         wait_for_results();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_full(250);
      test_pause_until_drained();
      test_random_small(200);
      test_random_collinear(150);
      test_random_touching(120);
      test_random_full(250);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_disjoint.size() == 0)
         $display("** segment_disjoint_test: PASSED **");
      else
         $display("** segment_disjoint_test: FAILED **");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sdt_pkg.sv
rtl/core/sdt_diff.sv
rtl/core/sdt_mult.sv
rtl/core/sdt_sum.sv
rtl/core/sdt_decide.sv
rtl/core/segment_disjoint_test.sv
tb/sv/tb.sv
